[rtl/iis_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iis_pkg;

    localparam int PIX_W        = 24;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_W     = 13;
    localparam int FACTOR_REG_W = 5;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int HEIGHT_LIMIT = 4096;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PIXEL  = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    // scale modes
    localparam logic MODE_ENLARGE = 1'b0;
    localparam logic MODE_SHRINK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       frame_end;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

[rtl/iis_line_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module iis_line_mem
    import iis_pkg::*;
#(
    parameter  int DEPTH  = 4096,
    parameter  int DATA_W = 24,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/integer_image_scaler.sv]
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor integer image scaler for 24-bit pixels in row order.
// Channels: req (push a pixel or pull a replayed pixel), res (result words),
// cfg (register writes: mode, factor, width, height by index 0..3). cfg_ready
// is always high; write configuration only while the block is idle. Writing
// index 0..3 restarts the frame position and cancels a pending replay.
// Enlarge: a push yields factor words, one per cycle unless res stalls, and
// stores the pixel in the line memory; after a row, factor-1 replays of the row
// are pulled one word per pull, read from the line memory; pushes are rejected.
// Shrink: a push yields one word at the last pixel of each full block, or none.
// A request word is loaded into the decode stage when it is accepted, as is the
// line memory read for a pull, and then moves into the output register that
// drives res. One request per cycle is taken while the output moves, except an
// enlarge push, which holds the decode stage until its factor copies drain.
// A stalled receiver holds the output register; one more request that yields
// a word is taken into the decode stage, then req_ready drops until the output
// moves.
// Reset: mode enlarge, factor 1, width 1, height 1, position cleared; the line
// memory is not cleared and needs no sweep.
module integer_image_scaler
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output res_t                       res_data
);

    localparam int AW = $clog2(MAX_WIDTH);      // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);  // width value
    localparam int SW = WW + 2;                 // column sums
    localparam int FW = $clog2(MAX_FACTOR + 1); // factor value
    localparam int RW = HEIGHT_W + 1;           // row sums

    // decode stage entry: one request word that produces cnt result words
    typedef struct packed {
        logic [1:0]       status;
        logic             use_mem;
        logic [PIX_W-1:0] pix;
        logic             row_end;
        logic [1:0]       pad;
        logic             frame_end;
        logic [FW-1:0]    cnt;
    } desc_t;

    // configuration registers
    logic                    mode_reg, mode_next;
    logic [FACTOR_REG_W-1:0] factor_reg, factor_next;
    logic [HEIGHT_W-1:0]     width_reg, width_next;
    logic [HEIGHT_W-1:0]     height_reg, height_next;

    // frame position
    logic [AW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [FW-1:0]    replays_reg, replays_next;
    logic [AW-1:0]    rcol_reg, rcol_next;
    logic [FW-1:0]    rcopy_reg, rcopy_next;
    // shrink block phases
    logic [FW-1:0]    col_ph_reg, col_ph_next;
    logic [FW-1:0]    row_ph_reg, row_ph_next;
    logic [1:0]       blk_cnt_reg, blk_cnt_next;

    // decode stage and output register
    logic          s1_valid_reg, s1_valid_next;
    desc_t         s1_reg, s1_next;
    logic [FW-1:0] copy_reg, copy_next;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg, res_next;

    // effective settings
    logic [FW-1:0]       sf;
    logic [FW-1:0]       sf_m1;
    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [3:0]          pad_prod;
    logic [1:0]          pad_up;

    logic cfg_fire;
    logic cfg_known;
    logic req_fire;
    logic out_free;
    logic s1_move;
    logic s1_last_copy;
    logic s1_done;

    // decode results
    desc_t   entry;
    logic    has_entry;
    logic    mem_wr;
    logic    mem_rd;
    logic [PIX_W-1:0] mem_rdata;

    logic [SW-1:0] col_p1;
    logic [SW-1:0] rcol_p1;
    logic [SW-1:0] col_psf;
    logic [RW-1:0] row_p1;
    logic [RW-1:0] row_psf;
    logic          row_done;

    logic [PIX_W-1:0] out_pix;

    always_comb
    begin
        if (factor_reg == '0)
            sf = FW'(1);
        else if (32'(factor_reg) > MAX_FACTOR)
            sf = FW'(MAX_FACTOR);
        else
            sf = FW'(factor_reg);

        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HEIGHT_W'(1);
        else if (32'(height_reg) > HEIGHT_LIMIT)
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    assign sf_m1    = sf - FW'(1);
    // (width * factor) mod 4 only needs the low two bits of each
    assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, sf[1:0]};
    assign pad_up   = pad_prod[1:0];

    assign col_p1  = SW'(in_col_reg) + SW'(1);
    assign rcol_p1 = SW'(rcol_reg) + SW'(1);
    assign col_psf = SW'(in_col_reg) + SW'(sf);
    assign row_p1  = RW'(in_row_reg) + RW'(1);
    assign row_psf = RW'(in_row_reg) + RW'(sf);
    assign row_done = col_p1 >= SW'(w_eff);

    // handshakes
    assign cfg_ready    = 1'b1;
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign cfg_known    = (cfg_index == REG_MODE) || (cfg_index == REG_FACTOR)
                       || (cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT);
    assign out_free     = !res_valid_reg || res_ready;
    assign s1_last_copy = (copy_reg + FW'(1)) == s1_reg.cnt;
    assign s1_move      = s1_valid_reg && out_free;
    assign s1_done      = s1_move && s1_last_copy;
    // take a new word when the decode stage is empty or hands off its last copy
    assign req_ready    = !s1_valid_reg || s1_done;
    assign req_fire     = req_valid && req_ready;

    // configuration writes
    always_comb
    begin
        mode_next   = mode_reg;
        factor_next = factor_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_fire)
        begin
            case (cfg_index)
                REG_MODE:   mode_next   = cfg_data[0];
                REG_FACTOR: factor_next = cfg_data[FACTOR_REG_W-1:0];
                REG_WIDTH:  width_next  = cfg_data[HEIGHT_W-1:0];
                REG_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // request decode and position update
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        replays_next = replays_reg;
        rcol_next    = rcol_reg;
        rcopy_next   = rcopy_reg;
        col_ph_next  = col_ph_reg;
        row_ph_next  = row_ph_reg;
        blk_cnt_next = blk_cnt_reg;

        entry           = '0;
        entry.cnt       = FW'(1);
        has_entry       = 1'b1;
        mem_wr          = 1'b0;
        mem_rd          = 1'b0;

        if (req_data.req_type == REQ_PULL)
        begin
            if (replays_reg == '0)
            begin
                entry.status = ST_EMPTY;
            end
            else
            begin
                entry.status    = ST_PIXEL;
                entry.use_mem   = 1'b1;
                entry.row_end   = (rcol_p1 >= SW'(w_eff)) && (rcopy_reg == sf_m1);
                entry.pad       = pad_up;
                entry.frame_end = entry.row_end && (replays_reg == FW'(1))
                               && (in_row_reg == '0);
                mem_rd          = req_fire;
                // advance the replay copy, column and pass
                if (rcopy_reg == sf_m1)
                begin
                    rcopy_next = '0;
                    if (rcol_p1 >= SW'(w_eff))
                    begin
                        rcol_next    = '0;
                        replays_next = replays_reg - FW'(1);
                    end
                    else
                    begin
                        rcol_next = rcol_reg + AW'(1);
                    end
                end
                else
                begin
                    rcopy_next = rcopy_reg + FW'(1);
                end
            end
        end
        else if (replays_reg != '0)
        begin
            // drop the pushed pixel
            entry.status = ST_REJECT;
        end
        else if (mode_reg == MODE_ENLARGE)
        begin
            entry.status    = ST_PIXEL;
            entry.pix       = {req_data.red_in, req_data.green_in, req_data.blue_in};
            entry.row_end   = row_done;
            entry.pad       = pad_up;
            entry.frame_end = row_done && (sf == FW'(1)) && (row_p1 >= RW'(h_eff));
            entry.cnt       = sf;
            mem_wr          = req_fire;
            if (row_done)
            begin
                in_col_next  = '0;
                in_row_next  = (row_p1 >= RW'(h_eff)) ? '0 : ROW_W'(row_p1);
                replays_next = sf_m1;
                rcol_next    = '0;
                rcopy_next   = '0;
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
        end
        else
        begin
            // shrink: keep the bottom-right pixel of each full block
            has_entry       = (col_ph_reg == sf_m1) && (row_ph_reg == sf_m1);
            entry.status    = ST_PIXEL;
            entry.pix       = {req_data.red_in, req_data.green_in, req_data.blue_in};
            entry.row_end   = col_psf >= SW'(w_eff);
            entry.pad       = blk_cnt_reg + 2'd1;
            entry.frame_end = entry.row_end && (row_psf >= RW'(h_eff));
            if (col_ph_reg == sf_m1)
            begin
                col_ph_next  = '0;
                blk_cnt_next = blk_cnt_reg + 2'd1;
            end
            else
            begin
                col_ph_next = col_ph_reg + FW'(1);
            end
            if (row_done)
            begin
                in_col_next  = '0;
                col_ph_next  = '0;
                blk_cnt_next = '0;
                if (row_p1 >= RW'(h_eff))
                begin
                    in_row_next = '0;
                    row_ph_next = '0;
                end
                else
                begin
                    in_row_next = ROW_W'(row_p1);
                    row_ph_next = (row_ph_reg == sf_m1) ? '0 : row_ph_reg + FW'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
        end

        // hold the position unless a word is taken; a known register write restarts it
        if (!req_fire)
        begin
            in_col_next  = in_col_reg;
            in_row_next  = in_row_reg;
            replays_next = replays_reg;
            rcol_next    = rcol_reg;
            rcopy_next   = rcopy_reg;
            col_ph_next  = col_ph_reg;
            row_ph_next  = row_ph_reg;
            blk_cnt_next = blk_cnt_reg;
        end
        if (cfg_fire && cfg_known)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            replays_next = '0;
            rcol_next    = '0;
            rcopy_next   = '0;
            col_ph_next  = '0;
            row_ph_next  = '0;
            blk_cnt_next = '0;
        end
    end

    // line memory: pushes write, pulls read. A pull is only taken after the
    // row's last push has been written, so no forwarding is needed.
    iis_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (in_col_reg),
        .wr_data (entry.pix),
        .rd_en   (mem_rd),
        .rd_addr (rcol_reg),
        .rd_data (mem_rdata)
    );

    // decode stage: emit one copy per cycle into the output register while it is free
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        copy_next     = copy_reg;
        if (s1_move)
        begin
            if (s1_last_copy)
                s1_valid_next = 1'b0;
            else
                copy_next = copy_reg + FW'(1);
        end
        if (req_fire && has_entry)
        begin
            s1_valid_next = 1'b1;
            s1_next       = entry;
            copy_next     = '0;
        end
    end

    assign out_pix = s1_reg.use_mem ? mem_rdata : s1_reg.pix;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (s1_move)
        begin
            res_valid_next      = 1'b1;
            res_next.status     = s1_reg.status;
            res_next.blue_out   = out_pix[7:0];
            res_next.green_out  = out_pix[15:8];
            res_next.red_out    = out_pix[23:16];
            res_next.row_end    = s1_reg.row_end && s1_last_copy;
            res_next.pad_bytes  = (s1_reg.row_end && s1_last_copy) ? s1_reg.pad : 2'd0;
            res_next.frame_end  = s1_reg.frame_end && s1_last_copy;
            res_next.last       = s1_last_copy;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ENLARGE;
            factor_reg    <= FACTOR_REG_W'(1);
            width_reg     <= HEIGHT_W'(1);
            height_reg    <= HEIGHT_W'(1);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            replays_reg   <= '0;
            rcol_reg      <= '0;
            rcopy_reg     <= '0;
            col_ph_reg    <= '0;
            row_ph_reg    <= '0;
            blk_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            copy_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            factor_reg    <= factor_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            replays_reg   <= replays_next;
            rcol_reg      <= rcol_next;
            rcopy_reg     <= rcopy_next;
            col_ph_reg    <= col_ph_next;
            row_ph_reg    <= row_ph_next;
            blk_cnt_reg   <= blk_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            copy_reg      <= copy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        res_reg <= res_next;
    end

    // a replay is only ever pending in enlarge mode
    a_replay_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (replays_reg != '0) |-> (mode_reg == MODE_ENLARGE))
        else $error("replay pending outside enlarge mode");

    // the copy counter never runs past the entry's word count
    a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (copy_reg < s1_reg.cnt))
        else $error("copy counter out of range");

    // the input column stays inside the effective row width
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(in_col_reg) < SW'(w_eff)))
        else $error("input column beyond row width");

    // no new word while copies of the current one are still pending
    a_copy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_last_copy) |-> !req_ready)
        else $error("request taken while copies pending");

endmodule

`default_nettype wire
